// File: rtl/agwi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anchor grid warp interpolator package
// Shared widths, command codes, register map and state encoding.
// ----------------------------------------------------------------------------
package agwi_pkg;

    // Default grid capacity.
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // Configuration port.
    localparam int CFG_W  = 32;
    localparam int ADDR_W = 4;

    // Field widths.
    localparam int DIM_W    = 7;
    localparam int STEP_W   = 20;
    localparam int RECIP_W  = 25;
    localparam int CMD_W    = 2;
    localparam int COORD_W  = 16;
    localparam int AIDX_W   = 12;
    localparam int POS_W    = 24;
    localparam int CVALID_W = 4;

    // Cell mapping: coordinate (Q12.4) times reciprocal (Q1.24) gives Q.28.
    localparam int MAP_W   = COORD_W + RECIP_W;
    localparam int FRAC_W  = 28;
    localparam int CELL_W  = MAP_W - FRAC_W;
    localparam int WFRAC_W = 16;
    localparam int WLSB    = FRAC_W - WFRAC_W;
    localparam int WT_W    = WFRAC_W + 1;

    // Blend datapath widths.
    localparam int HB_W      = POS_W + WT_W + 1;
    localparam int SPLIT     = 20;
    localparam int VLO_W     = SPLIT + 1 + WT_W + 1;
    localparam int VHI_W     = HB_W - SPLIT + WT_W + 1;
    localparam int SUM_W     = 58;
    localparam int RND_SHIFT = 32;
    localparam int RND_W     = SUM_W - RND_SHIFT;

    // Memory word: x in the upper half, y in the lower half.
    localparam int WORD_W = 2 * POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_COLS  = 2'd0,
        REG_ROWS  = 2'd1,
        REG_STEP  = 2'd2,
        REG_RECIP = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_INDEX,
        ST_READ,
        ST_DRAIN,
        ST_WRITE,
        ST_FILL,
        ST_NOP
    } t_state;

endpackage

// File: rtl/agwi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module agwi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/anchor_grid_warp_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anchor grid warp interpolator core
// Keeps a grid of 2-D anchor positions in one RAM and answers bilinear
// warp queries, single anchor writes, identity refills of the grid and no-ops.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// beat follows on o_res_valid for one cycle, and it cannot be held off. In a
// query the four corner anchors are read one after another through the single
// read port of the anchor RAM and then pass a multiply and accumulate pipeline.
// An identity fill writes one anchor per cycle. The result beat appears in the
// cycle in which busy drops, so a new command may be issued in that cycle.
// Anchors are not cleared by reset; a query must only touch anchors that
// were written or filled since reset.
// ----------------------------------------------------------------------------
module anchor_grid_warp_interpolator_core #(
    parameter int MAX_COLS = agwi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = agwi_pkg::DEF_MAX_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  logic        [agwi_pkg::CMD_W-1:0]   i_command,
    input  logic        [agwi_pkg::COORD_W-1:0] i_pixel_u,
    input  logic        [agwi_pkg::COORD_W-1:0] i_pixel_v,
    input  logic        [agwi_pkg::AIDX_W-1:0]  i_anchor_index,
    input  logic signed [agwi_pkg::POS_W-1:0]   i_write_x,
    input  logic signed [agwi_pkg::POS_W-1:0]   i_write_y,
    // Result channel
    output logic                                o_res_valid,
    output logic signed [agwi_pkg::POS_W-1:0]   o_warped_x,
    output logic signed [agwi_pkg::POS_W-1:0]   o_warped_y,
    output logic        [agwi_pkg::CVALID_W-1:0] o_corner_valid,
    output logic                                o_done_res,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [agwi_pkg::ADDR_W-1:0]  paddr,
    input  logic        [agwi_pkg::CFG_W-1:0]   pwdata,
    output logic        [agwi_pkg::CFG_W-1:0]   prdata,
    output logic                                pready
);

    import agwi_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int TW    = CW + RW;
    localparam int IW    = CELL_W + CW + 1;

    localparam logic [1:0] LAST_CORNER = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Round half up at bit 32, then saturate to the position range.
    function automatic logic [POS_W-1:0] round_sat(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] biased;
        logic        [RND_W-1:0] rnd;
        logic [POS_W-1:0]        res;
        biased = sum + (SUM_W'(1) <<< (RND_SHIFT - 1));
        rnd    = biased[SUM_W-1:RND_SHIFT];
        if (rnd[RND_W-1:POS_W-1] == '0 || rnd[RND_W-1:POS_W-1] == '1) begin
            res = rnd[POS_W-1:0];
        end else if (rnd[RND_W-1]) begin
            res = POS_MIN;
        end else begin
            res = POS_MAX;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   r_grid_cols;
    logic [DIM_W-1:0]   r_grid_rows;
    logic [STEP_W-1:0]  r_cell_step;
    logic [RECIP_W-1:0] r_step_recip;
    logic               cfg_wr;
    t_reg               cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols  <= DIM_W'(2);
            r_grid_rows  <= DIM_W'(2);
            r_cell_step  <= STEP_W'(256);
            r_step_recip <= RECIP_W'(1) << 24;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_COLS:  r_grid_cols  <= pwdata[DIM_W-1:0];
                REG_ROWS:  r_grid_rows  <= pwdata[DIM_W-1:0];
                REG_STEP:  r_cell_step  <= pwdata[STEP_W-1:0];
                REG_RECIP: r_step_recip <= pwdata[RECIP_W-1:0];
                default:   r_step_recip <= r_step_recip;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (cfg_sel)
            REG_COLS:  prdata = CFG_W'(r_grid_cols);
            REG_ROWS:  prdata = CFG_W'(r_grid_rows);
            REG_STEP:  prdata = CFG_W'(r_cell_step);
            REG_RECIP: prdata = CFG_W'(r_step_recip);
            default:   prdata = '0;
        endcase
    end

    // Grid size clamped to the supported range.
    logic [CW-1:0] cols;
    logic [RW-1:0] rows;
    logic [TW-1:0] total;

    always_comb begin
        if (r_grid_cols < DIM_W'(2)) begin
            cols = CW'(2);
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(r_grid_cols);
        end
        if (r_grid_rows < DIM_W'(2)) begin
            rows = RW'(2);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(r_grid_rows);
        end
    end

    assign total = TW'(cols) * TW'(rows);

    // ------------------------------------------------------------------
    // Control and captured command
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    logic   accept;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    logic [COORD_W-1:0]     r_u, r_v;
    logic [AIDX_W-1:0]      r_aidx;
    logic signed [POS_W-1:0] r_wx, r_wy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_u    <= i_pixel_u;
            r_v    <= i_pixel_v;
            r_aidx <= i_anchor_index;
            r_wx   <= i_write_x;
            r_wy   <= i_write_y;
        end
    end

    // ------------------------------------------------------------------
    // Query: cell mapping and corner indexes
    // ------------------------------------------------------------------
    logic [MAP_W-1:0]   tu, tv;
    logic [CELL_W-1:0]  r_ci, r_cj;
    logic [WFRAC_W-1:0] r_p, r_q;

    assign tu = MAP_W'(r_u) * MAP_W'(r_step_recip);
    assign tv = MAP_W'(r_v) * MAP_W'(r_step_recip);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAP) begin
            r_ci <= tu[MAP_W-1:FRAC_W];
            r_cj <= tv[MAP_W-1:FRAC_W];
            r_p  <= tu[FRAC_W-1:WLSB];
            r_q  <= tv[FRAC_W-1:WLSB];
        end
    end

    logic [IW-1:0]           row_base;
    logic [IW-1:0]           corner_idx [CVALID_W];
    logic [AW-1:0]           r_idx      [CVALID_W];
    logic [CVALID_W-1:0]     r_cvalid;

    assign row_base      = IW'(r_ci) + IW'(r_cj) * IW'(cols);
    assign corner_idx[0] = row_base;
    assign corner_idx[1] = row_base + IW'(1);
    assign corner_idx[2] = row_base + IW'(cols);
    assign corner_idx[3] = row_base + IW'(cols) + IW'(1);

    // Corner indexes and their in-grid flags.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_INDEX) begin
            for (int k = 0; k < CVALID_W; k++) begin
                r_idx[k]    <= corner_idx[k][AW-1:0];
                r_cvalid[k] <= (corner_idx[k] < IW'(total));
            end
        end
    end

    // ------------------------------------------------------------------
    // Anchor RAM
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [1:0]        r_k;

    assign ram_raddr = r_idx[r_k];

    agwi_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_anchor_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Blend pipeline: horizontal weight, row sum, vertical weight, total
    // ------------------------------------------------------------------
    logic              r_rd_v, r_p_v, r_h_v, r_v_v, r_fin;
    logic [1:0]        r_rd_k, r_p_k;
    logic              r_h_row, r_v_row;

    logic [WT_W-1:0]          wx_near, wy_near;
    logic signed [WT_W:0]     wx_s, wy_s;
    logic signed [POS_W-1:0]  ax, ay;
    logic signed [HB_W-1:0]   px_c, py_c;
    logic signed [HB_W-1:0]   r_px, r_py, r_hx, r_hy;

    assign wx_near = (WT_W'(1) << WFRAC_W) - WT_W'(r_p);
    assign wy_near = (WT_W'(1) << WFRAC_W) - WT_W'(r_q);
    assign wx_s    = r_rd_k[0] ? $signed({2'b00, r_p}) : $signed({1'b0, wx_near});
    assign wy_s    = r_h_row   ? $signed({2'b00, r_q}) : $signed({1'b0, wy_near});

    // A corner whose linear index lies outside the grid contributes zero.
    assign ax   = r_cvalid[r_rd_k] ? $signed(ram_rdata[WORD_W-1:POS_W]) : '0;
    assign ay   = r_cvalid[r_rd_k] ? $signed(ram_rdata[POS_W-1:0])      : '0;
    assign px_c = ax * wx_s;
    assign py_c = ay * wx_s;

    // Row sums are split so each vertical product stays narrow.
    logic signed [HB_W-SPLIT-1:0] hx_hi, hy_hi;
    logic signed [SPLIT:0]        hx_lo, hy_lo;
    logic signed [VHI_W-1:0]      vxh_c, vyh_c, r_vxh, r_vyh;
    logic signed [VLO_W-1:0]      vxl_c, vyl_c, r_vxl, r_vyl;

    assign hx_hi = r_hx[HB_W-1:SPLIT];
    assign hy_hi = r_hy[HB_W-1:SPLIT];
    assign hx_lo = $signed({1'b0, r_hx[SPLIT-1:0]});
    assign hy_lo = $signed({1'b0, r_hy[SPLIT-1:0]});
    assign vxh_c = hx_hi * wy_s;
    assign vyh_c = hy_hi * wy_s;
    assign vxl_c = hx_lo * wy_s;
    assign vyl_c = hy_lo * wy_s;

    logic signed [SUM_W-1:0] vxh_ext, vyh_ext, vxl_ext, vyl_ext;
    logic signed [SUM_W-1:0] contrib_x, contrib_y, r_sx, r_sy;

    assign vxh_ext   = r_vxh;
    assign vyh_ext   = r_vyh;
    assign vxl_ext   = r_vxl;
    assign vyl_ext   = r_vyl;
    assign contrib_x = (vxh_ext <<< SPLIT) + vxl_ext;
    assign contrib_y = (vyh_ext <<< SPLIT) + vyl_ext;

    // Datapath registers of the blend pipeline.
    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_px <= px_c;
            r_py <= py_c;
        end
        if (r_p_v) begin
            if (r_p_k[0]) begin
                r_hx <= r_hx + r_px;
                r_hy <= r_hy + r_py;
            end else begin
                r_hx <= r_px;
                r_hy <= r_py;
            end
        end
        if (r_h_v) begin
            r_vxh <= vxh_c;
            r_vyh <= vyh_c;
            r_vxl <= vxl_c;
            r_vyl <= vyl_c;
        end
        if (r_v_v) begin
            if (r_v_row) begin
                r_sx <= r_sx + contrib_x;
                r_sy <= r_sy + contrib_y;
            end else begin
                r_sx <= contrib_x;
                r_sy <= contrib_y;
            end
        end
    end

    // ------------------------------------------------------------------
    // Identity fill walk
    // ------------------------------------------------------------------
    logic [CW-1:0]      r_fcol;
    logic [RW-1:0]      r_frow;
    logic [AW-1:0]      r_faddr;
    logic [POS_W-2:0]   r_fx, r_fy;
    logic [POS_W-1:0]   fx_sum, fy_sum;
    logic [POS_W-2:0]   fx_next, fy_next;
    logic               col_last, fill_last;

    assign fx_sum    = POS_W'(r_fx) + POS_W'(r_cell_step);
    assign fy_sum    = POS_W'(r_fy) + POS_W'(r_cell_step);
    assign fx_next   = fx_sum[POS_W-1] ? '1 : fx_sum[POS_W-2:0];
    assign fy_next   = fy_sum[POS_W-1] ? '1 : fy_sum[POS_W-2:0];
    assign col_last  = (r_fcol == cols - CW'(1));
    assign fill_last = col_last && (r_frow == rows - RW'(1));

    // Anchor write bounds check.
    logic wr_ok;
    assign wr_ok = (32'(r_aidx) < 32'(total));

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic                     r_res_valid, n_res_valid;
    logic signed [POS_W-1:0]  r_warped_x, n_warped_x;
    logic signed [POS_W-1:0]  r_warped_y, n_warped_y;
    logic [CVALID_W-1:0]      r_corner_valid, n_corner_valid;
    logic                     r_done_res, n_done_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
            r_k         <= '0;
            r_rd_v      <= 1'b0;
            r_rd_k      <= '0;
            r_p_v       <= 1'b0;
            r_p_k       <= '0;
            r_h_v       <= 1'b0;
            r_h_row     <= 1'b0;
            r_v_v       <= 1'b0;
            r_v_row     <= 1'b0;
            r_fin       <= 1'b0;
            r_fcol      <= '0;
            r_frow      <= '0;
            r_faddr     <= '0;
            r_fx        <= '0;
            r_fy        <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;

            // Corner read sequence and pipeline tags.
            if (accept) begin
                r_k <= '0;
            end else if (r_state == ST_READ) begin
                r_k <= r_k + 2'd1;
            end
            r_rd_v  <= (r_state == ST_READ);
            r_rd_k  <= r_k;
            r_p_v   <= r_rd_v;
            r_p_k   <= r_rd_k;
            r_h_v   <= r_p_v && r_p_k[0];
            r_h_row <= r_p_k[1];
            r_v_v   <= r_h_v;
            r_v_row <= r_h_row;
            r_fin   <= r_v_v && r_v_row;

            // Fill walk counters.
            if (accept) begin
                r_fcol  <= '0;
                r_frow  <= '0;
                r_faddr <= '0;
                r_fx    <= '0;
                r_fy    <= '0;
            end else if (r_state == ST_FILL) begin
                r_faddr <= r_faddr + AW'(1);
                if (col_last) begin
                    r_fcol <= '0;
                    r_fx   <= '0;
                    r_frow <= r_frow + RW'(1);
                    r_fy   <= fy_next;
                end else begin
                    r_fcol <= r_fcol + CW'(1);
                    r_fx   <= fx_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_warped_x     <= n_warped_x;
        r_warped_y     <= n_warped_y;
        r_corner_valid <= n_corner_valid;
        r_done_res     <= n_done_res;
    end

    // Next state, RAM write control and result beat.
    always_comb begin
        n_state        = r_state;
        ram_we         = 1'b0;
        ram_waddr      = AW'(r_aidx);
        ram_wdata      = {r_wx, r_wy};
        n_res_valid    = 1'b0;
        n_warped_x     = r_warped_x;
        n_warped_y     = r_warped_y;
        n_corner_valid = r_corner_valid;
        n_done_res     = r_done_res;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command))
                        CMD_QUERY: n_state = ST_MAP;
                        CMD_WRITE: n_state = ST_WRITE;
                        CMD_FILL:  n_state = ST_FILL;
                        CMD_NOP:   n_state = ST_NOP;
                        default:   n_state = ST_NOP;
                    endcase
                end
            end
            ST_MAP: begin
                n_state = ST_INDEX;
            end
            ST_INDEX: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                if (r_k == LAST_CORNER) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_fin) begin
                    n_state        = ST_IDLE;
                    n_res_valid    = 1'b1;
                    n_warped_x     = round_sat(r_sx);
                    n_warped_y     = round_sat(r_sy);
                    n_corner_valid = r_cvalid;
                    n_done_res     = 1'b1;
                end
            end
            ST_WRITE: begin
                ram_we         = wr_ok;
                n_state        = ST_IDLE;
                n_res_valid    = 1'b1;
                n_warped_x     = '0;
                n_warped_y     = '0;
                n_corner_valid = '0;
                n_done_res     = wr_ok;
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_faddr;
                ram_wdata = {1'b0, r_fx, 1'b0, r_fy};
                if (fill_last) begin
                    n_state        = ST_IDLE;
                    n_res_valid    = 1'b1;
                    n_warped_x     = '0;
                    n_warped_y     = '0;
                    n_corner_valid = '0;
                    n_done_res     = 1'b1;
                end
            end
            ST_NOP: begin
                n_state        = ST_IDLE;
                n_res_valid    = 1'b1;
                n_warped_x     = '0;
                n_warped_y     = '0;
                n_corner_valid = '0;
                n_done_res     = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res_valid    = r_res_valid;
    assign o_warped_x     = r_warped_x;
    assign o_warped_y     = r_warped_y;
    assign o_corner_valid = r_corner_valid;
    assign o_done_res     = r_done_res;

endmodule

// File: rtl/agwi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anchor grid warp interpolator port checker
// Watches the command and result ports of the core over time.
// ----------------------------------------------------------------------------
module agwi_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_res_valid,
    input logic signed [agwi_pkg::POS_W-1:0]    o_warped_x,
    input logic signed [agwi_pkg::POS_W-1:0]    o_warped_y,
    input logic        [agwi_pkg::CVALID_W-1:0] o_corner_valid,
    input logic                                 o_done_res
);

    // An accepted command makes the core busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Each command yields a single result beat, never two back to back.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result beats in consecutive cycles");

    // A result beat ends a command that was in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result beat without a command in progress");

    // A command that did not complete reports no position and no corners.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_done_res) |->
            (o_corner_valid == '0 && o_warped_x == '0 && o_warped_y == '0))
        else $error("incomplete command carries result data");

endmodule

bind anchor_grid_warp_interpolator_core agwi_checker u_agwi_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anchor grid warp interpolator core testbench
// Drives query, anchor write, identity fill and unknown commands with random
// gaps, predicts every result beat from a local model of the anchor grid and
// the configuration registers, and checks each beat field by field.
// ----------------------------------------------------------------------------
module testbench;
    import agwi_pkg::*;

    localparam int MAX_COLS      = DEF_MAX_COLS;
    localparam int MAX_ROWS      = DEF_MAX_ROWS;
    localparam int MESH_DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 155;
    localparam int SETTLE_CYCLES = 16;
    localparam longint UNIT_Q16  = 65536;

    typedef struct {
        logic signed [POS_W-1:0] warped_x;
        logic signed [POS_W-1:0] warped_y;
        logic [CVALID_W-1:0]     corner_valid;
        logic                    done;
    } warp_beat_t;

    // Block ports.
    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      start          = 1'b0;
    logic [CMD_W-1:0]          i_command      = '0;
    logic [COORD_W-1:0]        i_pixel_u      = '0;
    logic [COORD_W-1:0]        i_pixel_v      = '0;
    logic [AIDX_W-1:0]         i_anchor_index = '0;
    logic signed [POS_W-1:0]   i_write_x      = '0;
    logic signed [POS_W-1:0]   i_write_y      = '0;
    logic                      psel           = 1'b0;
    logic                      penable        = 1'b0;
    logic                      pwrite         = 1'b0;
    logic [ADDR_W-1:0]         paddr          = '0;
    logic [CFG_W-1:0]          pwdata         = '0;
    logic                      busy;
    logic                      o_res_valid;
    logic signed [POS_W-1:0]   o_warped_x;
    logic signed [POS_W-1:0]   o_warped_y;
    logic [CVALID_W-1:0]       o_corner_valid;
    logic                      o_done_res;
    logic [CFG_W-1:0]          prdata;
    logic                      pready;

    // Local copy of the configuration registers and the anchor grid.
    logic [DIM_W-1:0]          cols_reg  = 7'd2;
    logic [DIM_W-1:0]          rows_reg  = 7'd2;
    logic [STEP_W-1:0]         step_reg  = 20'd256;
    logic [RECIP_W-1:0]        recip_reg = 25'h1000000;
    logic signed [POS_W-1:0]   mesh_x [MESH_DEPTH];
    logic signed [POS_W-1:0]   mesh_y [MESH_DEPTH];

    warp_beat_t pending_warps[$];
    int mismatch_count     = 0;
    int beats_checked      = 0;
    int settings_programmed = 0;
    int queries_sent       = 0;
    int writes_sent        = 0;
    int fills_sent         = 0;
    int unknown_sent       = 0;
    int burst_left         = 0;
    int stall_cycles       = 0;

    anchor_grid_warp_interpolator_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_pixel_u      (i_pixel_u),
        .i_pixel_v      (i_pixel_v),
        .i_anchor_index (i_anchor_index),
        .i_write_x      (i_write_x),
        .i_write_y      (i_write_y),
        .o_res_valid    (o_res_valid),
        .o_warped_x     (o_warped_x),
        .o_warped_y     (o_warped_y),
        .o_corner_valid (o_corner_valid),
        .o_done_res     (o_done_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Size registers are clamped to between 2 and the grid capacity before any use.
    function automatic int unsigned grid_dim(logic [DIM_W-1:0] value, int unsigned hi);
        if (value < 2) return 2;
        if (value > hi) return hi;
        return value;
    endfunction

    function automatic logic signed [POS_W-1:0] clip_pos(longint value);
        if (value > longint'(8388607)) return 24'sh7FFFFF;
        if (value < -longint'(8388608)) return 24'sh800000;
        return value[POS_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] reg_mask(t_reg idx);
        case (idx)
            REG_COLS, REG_ROWS: return 32'h7F;
            REG_STEP:           return 32'hFFFFF;
            default:            return 32'h1FFFFFF;
        endcase
    endfunction

    // Works out the result beat of one command and applies its effect on the grid.
    function automatic warp_beat_t predict_warp_command(t_cmd cmd, logic [COORD_W-1:0] u,
            logic [COORD_W-1:0] v, logic [AIDX_W-1:0] aidx,
            logic signed [POS_W-1:0] wx, logic signed [POS_W-1:0] wy);
        warp_beat_t beat;
        int unsigned cols, rows, total, ci, cj, idx, di, dj;
        logic [MAP_W-1:0] tu, tv;
        longint p, q, wgt, sx, sy;
        cols  = grid_dim(cols_reg, MAX_COLS);
        rows  = grid_dim(rows_reg, MAX_ROWS);
        total = cols * rows;
        beat.warped_x     = '0;
        beat.warped_y     = '0;
        beat.corner_valid = '0;
        beat.done         = 1'b0;
        case (cmd)
            CMD_QUERY: begin
                tu = MAP_W'(u) * MAP_W'(recip_reg);
                tv = MAP_W'(v) * MAP_W'(recip_reg);
                ci = tu[MAP_W-1:FRAC_W];
                cj = tv[MAP_W-1:FRAC_W];
                p  = tu[FRAC_W-1:WLSB];
                q  = tv[FRAC_W-1:WLSB];
                sx = 0;
                sy = 0;
                // Corners outside the linear index range add nothing.
                for (int k = 0; k < 4; k++) begin
                    di  = k & 1;
                    dj  = k >> 1;
                    idx = ci + di + (cj + dj) * cols;
                    wgt = (di != 0 ? p : UNIT_Q16 - p) * (dj != 0 ? q : UNIT_Q16 - q);
                    if (idx < total) begin
                        beat.corner_valid[k] = 1'b1;
                        sx += longint'(mesh_x[idx]) * wgt;
                        sy += longint'(mesh_y[idx]) * wgt;
                    end
                end
                // Round half up on the Q24.32 weighted sum.
                beat.warped_x = clip_pos((sx + (longint'(1) <<< 31)) >>> 32);
                beat.warped_y = clip_pos((sy + (longint'(1) <<< 31)) >>> 32);
                beat.done     = 1'b1;
            end
            CMD_WRITE: begin
                if (aidx < total) begin
                    mesh_x[aidx] = wx;
                    mesh_y[aidx] = wy;
                    beat.done    = 1'b1;
                end
            end
            CMD_FILL: begin
                for (int r = 0; r < rows; r++) begin
                    for (int c = 0; c < cols; c++) begin
                        mesh_x[c + r * cols] = clip_pos(longint'(c) * longint'(step_reg));
                        mesh_y[c + r * cols] = clip_pos(longint'(r) * longint'(step_reg));
                    end
                end
                beat.done = 1'b1;
            end
            default: begin
            end
        endcase
        return beat;
    endfunction

    // Sends one command after a random gap and records its expected result.
    task automatic issue_command(t_cmd cmd, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
            logic [AIDX_W-1:0] aidx, logic signed [POS_W-1:0] wx,
            logic signed [POS_W-1:0] wy);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(8, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 18);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= cmd;
        i_pixel_u      <= u;
        i_pixel_v      <= v;
        i_anchor_index <= aidx;
        i_write_x      <= wx;
        i_write_y      <= wy;
        do @(posedge i_clk); while (busy);
        pending_warps.push_back(predict_warp_command(cmd, u, v, aidx, wx, wy));
        case (cmd)
            CMD_QUERY: queries_sent++;
            CMD_WRITE: writes_sent++;
            CMD_FILL:  fills_sent++;
            default:   unknown_sent++;
        endcase
    endtask

    // Unused fields of each command carry random values.
    task automatic issue_query(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        issue_command(CMD_QUERY, u, v, AIDX_W'($urandom), POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic issue_write(logic [AIDX_W-1:0] aidx, logic signed [POS_W-1:0] wx,
            logic signed [POS_W-1:0] wy);
        issue_command(CMD_WRITE, COORD_W'($urandom), COORD_W'($urandom), aidx, wx, wy);
    endtask

    task automatic issue_fill();
        issue_command(CMD_FILL, COORD_W'($urandom), COORD_W'($urandom), AIDX_W'($urandom),
                POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic issue_unknown();
        issue_command(CMD_NOP, COORD_W'($urandom), COORD_W'($urandom), AIDX_W'($urandom),
                POS_W'($urandom), POS_W'($urandom));
    endtask

    // Drops start and waits until every expected beat has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_warps.size() != 0) @(posedge i_clk);
    endtask

    // Writes one register over the APB port, then reads it back.
    task automatic write_register(t_reg idx, logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] stored;
        value  = value | ($urandom & ~reg_mask(idx));
        stored = value & reg_mask(idx);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COLS: cols_reg  = stored[DIM_W-1:0];
            REG_ROWS: rows_reg  = stored[DIM_W-1:0];
            REG_STEP: step_reg  = stored[STEP_W-1:0];
            default:  recip_reg = stored[RECIP_W-1:0];
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) begin
            $display("%0t register %s readback: expected %h, actual %h",
                    $time, idx.name(), stored, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_grid(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows,
            logic [CFG_W-1:0] step, logic [CFG_W-1:0] recip);
        write_register(REG_COLS, cols);
        write_register(REG_ROWS, rows);
        write_register(REG_STEP, step);
        write_register(REG_RECIP, recip);
        settings_programmed++;
    endtask

    // Coordinates mostly land inside or just past the grid, sometimes anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(int unsigned dim);
        longint span;
        if (recip_reg == 0 || $urandom_range(0, 3) == 0) return COORD_W'($urandom);
        span = ((longint'(dim) + 1) << FRAC_W) / longint'(recip_reg);
        if (span > 65535) span = 65535;
        return COORD_W'($urandom_range(0, int'(span)));
    endfunction

    task automatic issue_random_command();
        int unsigned cols, rows, sel;
        logic [AIDX_W-1:0] aidx;
        cols = grid_dim(cols_reg, MAX_COLS);
        rows = grid_dim(rows_reg, MAX_ROWS);
        sel  = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) aidx = AIDX_W'($urandom);
        else aidx = AIDX_W'($urandom_range(0, cols * rows - 1));
        if (sel < 64) issue_query(pick_coord(cols), pick_coord(rows));
        else if (sel < 86) issue_write(aidx, POS_W'($urandom), POS_W'($urandom));
        else if (sel < 91) issue_fill();
        else issue_unknown();
    endtask

    // Grid sizes are mostly small so that fills stay short.
    task automatic program_random_grid();
        logic [CFG_W-1:0] cols, rows, step, recip;
        int unsigned eff_cols;
        case ($urandom_range(0, 7))
            0:       cols = $urandom_range(0, 1);
            1:       cols = $urandom_range(64, 127);
            default: cols = $urandom_range(2, 16);
        endcase
        case ($urandom_range(0, 7))
            0:       rows = $urandom_range(0, 1);
            1:       rows = $urandom_range(64, 127);
            default: rows = $urandom_range(2, 16);
        endcase
        case ($urandom_range(0, 5))
            0:       step = 0;
            1:       step = 32'hFFFFF;
            2:       step = $urandom_range(0, 32'hFFFFF);
            default: step = $urandom_range(64, 1024);
        endcase
        eff_cols = grid_dim(cols[DIM_W-1:0], MAX_COLS);
        case ($urandom_range(0, 4))
            0:       recip = $urandom_range(0, 32'h1FFFFFF);
            1:       recip = 32'h1000000;
            default: recip = $urandom_range(eff_cols * 2048, eff_cols * 8192);
        endcase
        program_grid(cols, rows, step, recip);
    endtask

    // Reset settings: a 2 by 2 grid, unit step and unit reciprocal.
    task automatic test_reset_grid();
        issue_unknown();
        issue_fill();
        issue_query(16'd0, 16'd0);
        issue_query(16'd8, 16'd8);
        // Right corners wrap into the next row, the far ones leave the grid.
        issue_query(16'd24, 16'd4);
        issue_query(16'hFFFF, 16'hFFFF);
        issue_write(12'd3, 24'sh7FFFFF, 24'sh800000);
        issue_write(12'd4, 24'sh123456, 24'sh654321);
        issue_write(12'hFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        issue_query(16'd8, 16'd8);
    endtask

    // Register extremes: clamped sizes, saturating fill, zero step and reciprocal.
    task automatic test_register_extremes();
        drain_results();
        program_grid(32'd127, 32'd127, 32'hFFFFF, 32'h1FFFFFF);
        issue_fill();
        issue_query(16'd0, 16'd0);
        issue_query(16'd1, 16'd1);
        issue_query(16'h0FFF, 16'h0040);
        issue_query(16'hFFFF, 16'hFFFF);
        drain_results();
        program_grid(32'd0, 32'd1, 32'd0, 32'd0);
        issue_query(16'hFFFF, 16'd12345);
        issue_fill();
        issue_write(12'd0, 24'sh800000, 24'sh7FFFFF);
        issue_query(16'd0, 16'd0);
    endtask

    // Full 64 by 64 grid with the last column and row at the borders.
    task automatic test_grid_borders();
        drain_results();
        program_grid(32'd64, 32'd64, 32'd256, 32'd262144);
        issue_write(12'd4095, 24'sh800000, 24'sh7FFFFF);
        issue_write(12'd63, 24'sh7FFFFF, 24'sh800000);
        issue_query(16'hFFFF, 16'd0);
        issue_query(16'd0, 16'hFFFF);
        issue_query(16'hFFFF, 16'hFFFF);
        issue_query(16'd512, 16'd512);
    endtask

    // Every phase starts from an idle block with fresh register settings.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            program_random_grid();
            repeat (PHASE_ITEMS) issue_random_command();
        end
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Each result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        warp_beat_t want;
        if (i_rst_n && o_res_valid) begin
            if (pending_warps.size() == 0) begin
                $display("%0t unexpected result beat: expected none, actual x=%h y=%h",
                        $time, o_warped_x, o_warped_y);
                mismatch_count++;
            end else begin
                want = pending_warps.pop_front();
                compare_field("warped_x", want.warped_x, o_warped_x);
                compare_field("warped_y", want.warped_y, o_warped_y);
                compare_field("corner_valid", want.corner_valid, o_corner_valid);
                compare_field("done_res", want.done, o_done_res);
                beats_checked++;
            end
        end
    end

    // Ends the run when neither a command nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
                $display("** anchor_grid_warp_interpolator_core: FAILED **");
                $finish;
            end
        end
    end

    // The reset grid is filled before any query, and the extremes test fills
    // the whole store, so no query ever reads an anchor that was never written.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_grid();
        test_register_extremes();
        test_grid_borders();
        test_random_traffic();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d queries, %0d anchor writes, %0d identity fills, %0d unknown commands.",
                queries_sent, writes_sent, fills_sent, unknown_sent);
        $display("Checked %0d result beats over %0d register settings.",
                beats_checked, settings_programmed);
        if (mismatch_count == 0 && pending_warps.size() == 0) begin
            $display("** anchor_grid_warp_interpolator_core: PASSED **");
        end else begin
            $display("** anchor_grid_warp_interpolator_core: FAILED **");
        end
        $finish;
    end

endmodule
